>>> hw/rtl/gccd_pkg.sv
// shared constants and types for the grid convex corner detector
`timescale 1ns / 1ps
`default_nettype none
package gccd_pkg;

  // default grid limits
  localparam int unsigned GCCD_MAX_ROWS = 1024;
  localparam int unsigned GCCD_MAX_COLS = 1024;

  // configuration port
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS = 4'd0,
    REG_GRID_ROWS    = 4'd1
  } gccd_reg_t;

  // result coordinate width
  localparam int unsigned OUT_W = 10;

  // scan control towards the window stage
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic restart;  // configuration write, scan starts over
  } gccd_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/gccd_ram.sv
// generic single-clock ram with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module gccd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read-first: a read and write to one address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gccd_scan.sv
// configuration registers, dimension clamping and grid position counters
`timescale 1ns / 1ps
`default_nettype none
module gccd_scan #(
  parameter int unsigned MAX_ROWS = gccd_pkg::GCCD_MAX_ROWS,
  parameter int unsigned MAX_COLS = gccd_pkg::GCCD_MAX_COLS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [gccd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gccd_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                accept,
  output logic      [$clog2(MAX_COLS)-1:0]         col,
  output logic      [$clog2(MAX_ROWS)-1:0]         row,
  output gccd_pkg::gccd_ctl_t                      ctl
);
  import gccd_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_COLS);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned CLW0 = $clog2(MAX_COLS + 1);
  localparam int unsigned RLW0 = $clog2(MAX_ROWS + 1);
  localparam int unsigned CLW  = (CLW0 > CFG_W) ? CLW0 : CFG_W;
  localparam int unsigned RLW  = (RLW0 > CFG_W) ? RLW0 : CFG_W;

  logic [CFG_W-1:0] cols_cfg_r, rows_cfg_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CLW-1:0]   cols_ext, cols_eff, col_inc;
  logic [RLW-1:0]   rows_ext, rows_eff, row_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= CFG_DIM_RESET;
      rows_cfg_r <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_COLUMNS: cols_cfg_r <= cfg_wdata;
        REG_GRID_ROWS:    rows_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturate into 2..max
  always_comb begin
    cols_ext = CLW'(cols_cfg_r);
    rows_ext = RLW'(rows_cfg_r);
    if (cols_ext < CLW'(2))             cols_eff = CLW'(2);
    else if (cols_ext > CLW'(MAX_COLS)) cols_eff = CLW'(MAX_COLS);
    else                                cols_eff = cols_ext;
    if (rows_ext < RLW'(2))             rows_eff = RLW'(2);
    else if (rows_ext > RLW'(MAX_ROWS)) rows_eff = RLW'(MAX_ROWS);
    else                                rows_eff = rows_ext;
  end

  always_comb begin
    col_inc = CLW'(col_r) + CLW'(1);
    row_inc = RLW'(row_r) + RLW'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (row_inc >= rows_eff) begin
      row_nxt = '0;
      col_nxt = (col_inc >= cols_eff) ? '0 : CW'(col_inc);
    end else begin
      row_nxt = RW'(row_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col         = col_r;
  assign row         = row_r;
  assign ctl.accept  = accept;
  assign ctl.restart = cfg_we;

endmodule
`default_nettype wire

>>> hw/rtl/gccd_window.sv
// 2x2 window stage register, corner evaluation and result register
`timescale 1ns / 1ps
`default_nettype none
module gccd_window #(
  parameter int unsigned MAX_ROWS = gccd_pkg::GCCD_MAX_ROWS,
  parameter int unsigned MAX_COLS = gccd_pkg::GCCD_MAX_COLS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gccd_pkg::gccd_ctl_t           ctl,
  input  wire logic                          in_occupied,
  input  wire logic [$clog2(MAX_COLS)-1:0]   col,
  input  wire logic [$clog2(MAX_ROWS)-1:0]   row,
  input  wire logic                          line_rdata,
  output logic                               in_ready,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic      [gccd_pkg::OUT_W-1:0]    out_corner_col,
  output logic      [gccd_pkg::OUT_W-1:0]    out_corner_row
);
  import gccd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);

  logic          s1_valid_r;
  logic          s1_occ_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          held_cur_r, held_prev_r;
  logic          out_valid_r;
  logic [OUT_W-1:0] corner_col_r, corner_row_r;

  logic          out_free, s1_adv, hit, one_hot;
  logic          cell00, cell01, cell10, cell11;
  logic [CW-1:0] col_sel;
  logic [RW-1:0] row_sel;
  logic [31:0]   col_ext, row_ext;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  assign cell00 = held_prev_r;
  assign cell10 = held_cur_r;
  assign cell01 = line_rdata;
  assign cell11 = s1_occ_r;

  always_comb begin
    one_hot = ({1'b0, cell00} + {1'b0, cell01} + {1'b0, cell10} + {1'b0, cell11}) == 2'd1;
    hit     = one_hot && (s1_col_r != '0) && (s1_row_r != '0);
    // free cell opposite the occupied one
    col_sel = s1_col_r;
    row_sel = s1_row_r;
    if (cell11) begin
      col_sel = s1_col_r - CW'(1);
      row_sel = s1_row_r - RW'(1);
    end else if (cell10) begin
      col_sel = s1_col_r - CW'(1);
    end else if (cell01) begin
      row_sel = s1_row_r - RW'(1);
    end
    col_ext = 32'(col_sel);
    row_ext = 32'(row_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ctl.accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_occ_r <= in_occupied;
      s1_col_r <= col;
      s1_row_r <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      held_cur_r  <= 1'b0;
      held_prev_r <= 1'b0;
    end else if (s1_adv) begin
      held_cur_r  <= cell11;
      held_prev_r <= cell01;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= hit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && hit) begin
      corner_col_r <= col_ext[OUT_W-1:0];
      corner_row_r <= row_ext[OUT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_corner_col = corner_col_r;
  assign out_corner_row = corner_row_r;

endmodule
`default_nettype wire

>>> hw/rtl/grid_convex_corner_detect_top.sv
// top level of the grid convex corner detector
`timescale 1ns / 1ps
`default_nettype none
// Streams a binary occupancy grid one cell per transfer, column-major (all rows
// of column 0, then column 1, ...), and reports a convex corner node whenever
// the 2x2 window over columns c-1..c and rows r-1..r holds exactly one
// occupied cell: the result is the free cell diagonally opposite it. The block
// takes one cell every clock cycle; a completed window is held in the window
// stage and its result in the result register, and output back-pressure
// only stalls the input once both the window stage and the result register
// are full. That rate is set by the previous-column line buffer, a single
// ram of MAX_ROWS bits that is read and written once per cell at the cell's
// row (read-first). No clearing pass is needed after reset: any configuration
// write, to any index, restarts the scan at cell (0, 0), and the first column
// fills the buffer before it is ever used. Dimensions saturate into 2..MAX,
// and after the last cell of a frame the scan wraps to a new frame.
module grid_convex_corner_detect_top #(
  parameter int unsigned MAX_ROWS = gccd_pkg::GCCD_MAX_ROWS,
  parameter int unsigned MAX_COLS = gccd_pkg::GCCD_MAX_COLS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [gccd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gccd_pkg::CFG_W-1:0]      cfg_wdata,
  // cell input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_occupied,
  // corner results
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [gccd_pkg::OUT_W-1:0]      out_corner_col,
  output logic      [gccd_pkg::OUT_W-1:0]      out_corner_row
);
  import gccd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);

  logic          accept;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          line_rdata;
  gccd_ctl_t     ctl;

  // input transfer
  assign accept = in_valid && in_ready;

  // position of the incoming cell and config registers
  gccd_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .col       (col),
    .row       (row),
    .ctl       (ctl)
  );

  // previous column: the old word at this row comes out as the left cell,
  // the new cell goes in its place in the same cycle
  gccd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ROWS)
  ) u_line_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (row),
    .wdata (in_occupied),
    .re    (accept),
    .raddr (row),
    .rdata (line_rdata)
  );

  // window evaluation and result register
  gccd_window #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_occupied    (in_occupied),
    .col            (col),
    .row            (row),
    .line_rdata     (line_rdata),
    .in_ready       (in_ready),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_corner_col (out_corner_col),
    .out_corner_row (out_corner_row)
  );

endmodule
`default_nettype wire

>>> hw/rtl/gccd_checker.sv
// port-level checks for the grid convex corner detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module gccd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [gccd_pkg::OUT_W-1:0]      out_corner_col,
  input wire logic [gccd_pkg::OUT_W-1:0]      out_corner_row
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with no result pending the window stage can always drain, so input is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_corner_col) && $stable(out_corner_row))
    else $error("result payload changed while stalled");

endmodule

bind grid_convex_corner_detect_top gccd_checker u_gccd_checker (.*);
`default_nettype wire
